// ===== src/odmix_pkg.sv =====
`timescale 1ns / 1ps

package odmix_pkg;

  localparam int SineFracBits = 15;
  // signed sine: magnitude reaches 2^SineFracBits
  localparam int SinW    = SineFracBits + 2;
  localparam int AxisW   = SinW + 10;
  localparam int SumW    = AxisW + 1;
  localparam int ScaleW  = 20;
  localparam int MixW    = SumW + ScaleW + 1;
  localparam int MixShift = SineFracBits + 8;
  localparam int HiW     = 23;
  localparam int QW      = 14;
  localparam int YawW    = 16;
  localparam int WheelW  = 15;
  localparam int RecipW  = 24;
  localparam int DivProdW = HiW + RecipW;
  localparam int DivShift = 33;

  // floor division of the mix by 1000, done on an offset copy that is never negative
  localparam logic [RecipW-1:0] DivRecip = 24'd8589935;
  localparam logic [HiW-1:0]    UOffset  = 23'd4194000;
  localparam logic signed [YawW-1:0] QOffset = 16'sd4194;
  localparam logic [9:0]        DivBase  = 10'd1000;

  localparam logic [ScaleW-1:0] MixRatio   = 20'd707;
  localparam logic [9:0]        ScaleReset = 10'd797;
  localparam logic [5:0]        GainCompassReset = 6'd4;
  localparam logic [5:0]        GainTargetReset  = 6'd12;

  localparam logic [1:0] CfgGainCompass = 2'd0;
  localparam logic [1:0] CfgGainTarget  = 2'd1;
  localparam logic [1:0] CfgDriveScale  = 2'd2;

  localparam logic [1:0] RefCompass = 2'd0;
  localparam logic [1:0] RefGoal    = 2'd1;
  localparam logic [1:0] RefBall    = 2'd2;

  typedef struct packed {
    logic signed [SinW-1:0] sin_dir;
    logic signed [SinW-1:0] sin_cdir;
    logic [8:0]             speed;
    logic signed [YawW-1:0] yaw;
  } item_t;

  function automatic logic [17:0] sin_q17(input logic [6:0] k);
    logic [17:0] v;
    case (k)
      7'd0: v = 18'd0;        7'd1: v = 18'd2288;     7'd2: v = 18'd4574;
      7'd3: v = 18'd6860;     7'd4: v = 18'd9143;     7'd5: v = 18'd11424;
      7'd6: v = 18'd13701;    7'd7: v = 18'd15974;    7'd8: v = 18'd18242;
      7'd9: v = 18'd20504;    7'd10: v = 18'd22760;   7'd11: v = 18'd25010;
      7'd12: v = 18'd27251;   7'd13: v = 18'd29485;   7'd14: v = 18'd31709;
      7'd15: v = 18'd33924;   7'd16: v = 18'd36128;   7'd17: v = 18'd38322;
      7'd18: v = 18'd40503;   7'd19: v = 18'd42673;   7'd20: v = 18'd44829;
      7'd21: v = 18'd46972;   7'd22: v = 18'd49100;   7'd23: v = 18'd51214;
      7'd24: v = 18'd53312;   7'd25: v = 18'd55393;   7'd26: v = 18'd57458;
      7'd27: v = 18'd59505;   7'd28: v = 18'd61535;   7'd29: v = 18'd63545;
      7'd30: v = 18'd65536;   7'd31: v = 18'd67507;   7'd32: v = 18'd69458;
      7'd33: v = 18'd71387;   7'd34: v = 18'd73295;   7'd35: v = 18'd75180;
      7'd36: v = 18'd77042;   7'd37: v = 18'd78881;   7'd38: v = 18'd80696;
      7'd39: v = 18'd82486;   7'd40: v = 18'd84251;   7'd41: v = 18'd85991;
      7'd42: v = 18'd87704;   7'd43: v = 18'd89391;   7'd44: v = 18'd91050;
      7'd45: v = 18'd92682;   7'd46: v = 18'd94285;   7'd47: v = 18'd95860;
      7'd48: v = 18'd97405;   7'd49: v = 18'd98921;   7'd50: v = 18'd100407;
      7'd51: v = 18'd101862;  7'd52: v = 18'd103286;  7'd53: v = 18'd104679;
      7'd54: v = 18'd106039;  7'd55: v = 18'd107368;  7'd56: v = 18'd108664;
      7'd57: v = 18'd109926;  7'd58: v = 18'd111155;  7'd59: v = 18'd112351;
      7'd60: v = 18'd113512;  7'd61: v = 18'd114638;  7'd62: v = 18'd115730;
      7'd63: v = 18'd116786;  7'd64: v = 18'd117807;  7'd65: v = 18'd118792;
      7'd66: v = 18'd119740;  7'd67: v = 18'd120652;  7'd68: v = 18'd121528;
      7'd69: v = 18'd122366;  7'd70: v = 18'd123167;  7'd71: v = 18'd123931;
      7'd72: v = 18'd124657;  7'd73: v = 18'd125345;  7'd74: v = 18'd125994;
      7'd75: v = 18'd126606;  7'd76: v = 18'd127179;  7'd77: v = 18'd127713;
      7'd78: v = 18'd128208;  7'd79: v = 18'd128664;  7'd80: v = 18'd129081;
      7'd81: v = 18'd129458;  7'd82: v = 18'd129796;  7'd83: v = 18'd130095;
      7'd84: v = 18'd130354;  7'd85: v = 18'd130573;  7'd86: v = 18'd130753;
      7'd87: v = 18'd130892;  7'd88: v = 18'd130992;  7'd89: v = 18'd131052;
      7'd90: v = 18'd131072;
      default: v = 18'd0;
    endcase
    return v;
  endfunction

  // sine of a whole degree 0..359, rounded half up to SineFracBits
  function automatic logic signed [SinW-1:0] deg_sine(input logic [8:0] d);
    logic        neg;
    logic [8:0]  dd;
    logic [6:0]  k;
    logic [18:0] t;
    logic signed [SinW-1:0] mag;
    neg = (d >= 9'd180);
    dd  = neg ? (d - 9'd180) : d;
    k   = (dd > 9'd90) ? 7'(9'd180 - dd) : dd[6:0];
    t   = ({1'b0, sin_q17(k)} << 1) + 19'(1 << (17 - SineFracBits));
    t   = t >> (18 - SineFracBits);
    mag = SinW'(t);
    return neg ? -mag : mag;
  endfunction

endpackage

// ===== src/odmix_front.sv =====
`timescale 1ns / 1ps

module odmix_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [8:0]          speed_q8_i,
  input  logic [8:0]          travel_deg_i,
  input  logic [1:0]          heading_ref_i,
  input  logic signed [8:0]   compass_error_i,
  input  logic [8:0]          goal_bearing_i,
  input  logic [8:0]          ball_bearing_i,
  input  logic [5:0]          gain_compass_i,
  input  logic [5:0]          gain_target_i,
  output logic                item_valid_o,
  output odmix_pkg::item_t    item_o,
  input  logic                item_ready_i
);
  import odmix_pkg::*;

  logic        valid_q, valid_d;
  item_t       item_q, item_d;
  logic [8:0]  dir, cdir_raw, cdir;
  logic [8:0]  brg;
  logic signed [9:0] err;
  logic [5:0]  gain;
  logic signed [16:0] yaw_full;

  assign in_ready_o   = !valid_q || item_ready_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_comb begin
    dir      = (travel_deg_i >= 9'd360) ? (travel_deg_i - 9'd360) : travel_deg_i;
    cdir_raw = dir + 9'd90;
    cdir     = (cdir_raw >= 9'd360) ? (cdir_raw - 9'd360) : cdir_raw;

    brg = (heading_ref_i == RefBall) ? ball_bearing_i : goal_bearing_i;
    case (heading_ref_i)
      RefCompass: begin
        gain = gain_compass_i;
        err  = 10'(compass_error_i);
      end
      RefGoal, RefBall: begin
        gain = gain_target_i;
        // bearings past half a turn wrap to a positive error
        err  = (brg > 9'd180) ? (10'sd360 - signed'({1'b0, brg}))
                              : -signed'({1'b0, brg});
      end
      default: begin
        gain = 6'd0;
        err  = 10'sd0;
      end
    endcase
    yaw_full = signed'({1'b0, gain}) * err;

    item_d.sin_dir  = deg_sine(dir);
    item_d.sin_cdir = deg_sine(cdir);
    item_d.speed    = speed_q8_i;
    item_d.yaw      = YawW'(yaw_full);

    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== src/odmix_queue.sv =====
`timescale 1ns / 1ps

module odmix_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  odmix_pkg::item_t push_item_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output odmix_pkg::item_t pop_item_o
);
  import odmix_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== src/odmix_back.sv =====
`timescale 1ns / 1ps

module odmix_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  input  odmix_pkg::item_t    item_i,
  input  logic [odmix_pkg::ScaleW-1:0] scale_mix_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [odmix_pkg::WheelW-1:0] wheel_a_o,
  output logic signed [odmix_pkg::WheelW-1:0] wheel_b_o,
  output logic signed [odmix_pkg::WheelW-1:0] wheel_c_o,
  output logic signed [odmix_pkg::WheelW-1:0] wheel_d_o
);
  import odmix_pkg::*;

  // whole pipeline moves together; it only holds when the output beat waits
  logic adv;
  logic v1_q, v2_q, v3_q, v4_q, vo_q;

  // stage 1: axis components
  logic signed [AxisW-1:0] x_q, y_q;
  logic signed [YawW-1:0]  yaw1_q;
  // stage 2: mixes, lane 0 is y-x, lane 1 is x+y
  logic signed [MixW-1:0]  mix_q [2];
  logic signed [YawW-1:0]  yaw2_q;
  // stage 3: coarse quotient by 1000
  logic [HiW-1:0]          u_q   [2];
  logic [QW-1:0]           qu_q  [2];
  logic                    lonz_q[2];
  logic signed [YawW-1:0]  yaw3_q;
  // stage 4: floor quotient and inexact flag
  logic signed [YawW-1:0]  q_q   [2];
  logic                    rnz_q [2];
  logic signed [YawW-1:0]  yaw4_q;

  logic signed [WheelW-1:0] wa_q, wb_q, wc_q, wd_q;

  logic signed [SumW-1:0]  dsum [2];
  logic signed [MixW-1:0]  mix_d [2];
  logic signed [MixW-1:0]  mix_sh [2];
  logic [HiW-1:0]          u_d [2];
  logic [DivProdW-1:0]     dprod [2];
  logic [HiW-1:0]          back_mul [2];

  assign adv          = !vo_q || out_ready_i;
  assign item_ready_o = adv;
  assign out_valid_o  = vo_q;
  assign wheel_a_o    = wa_q;
  assign wheel_b_o    = wb_q;
  assign wheel_c_o    = wc_q;
  assign wheel_d_o    = wd_q;

  // yaw plus or minus the exact quotient mix/den, truncated toward zero and clamped
  function automatic logic signed [WheelW-1:0] finish(
    input logic signed [YawW-1:0] yaw,
    input logic signed [YawW-1:0] q,
    input logic                   rnz,
    input logic                   negate
  );
    logic signed [YawW+1:0] qq;
    logic signed [YawW+1:0] v;
    qq = (YawW+2)'(q);
    if (negate) begin
      qq = rnz ? (-qq - 18'sd1) : -qq;
    end
    v = (YawW+2)'(yaw) + qq;
    if (v < 0 && rnz) begin
      v = v + 18'sd1;
    end
    if (v > 18'sd16383) begin
      v = 18'sd16383;
    end else if (v < -18'sd16384) begin
      v = -18'sd16384;
    end
    return WheelW'(v);
  endfunction

  always_comb begin
    dsum[0] = SumW'(y_q) - SumW'(x_q);
    dsum[1] = SumW'(y_q) + SumW'(x_q);
    for (int i = 0; i < 2; i++) begin
      mix_d[i]    = dsum[i] * signed'({1'b0, scale_mix_i});
      mix_sh[i]   = mix_q[i] >>> MixShift;
      u_d[i]      = HiW'(mix_sh[i]) + UOffset;
      dprod[i]    = DivProdW'(u_d[i]) * DivProdW'(DivRecip);
      back_mul[i] = HiW'(qu_q[i] * DivBase);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v1_q <= item_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      vo_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q    <= item_i.sin_dir  * signed'({1'b0, item_i.speed});
      y_q    <= item_i.sin_cdir * signed'({1'b0, item_i.speed});
      yaw1_q <= item_i.yaw;

      yaw2_q <= yaw1_q;
      yaw3_q <= yaw2_q;
      yaw4_q <= yaw3_q;
      for (int i = 0; i < 2; i++) begin
        mix_q[i]  <= mix_d[i];
        u_q[i]    <= u_d[i];
        qu_q[i]   <= dprod[i][DivShift +: QW];
        lonz_q[i] <= |mix_q[i][MixShift-1:0];
        q_q[i]    <= signed'(YawW'(qu_q[i])) - QOffset;
        rnz_q[i]  <= lonz_q[i] || (u_q[i] != back_mul[i]);
      end

      wa_q <= finish(yaw4_q, q_q[1], rnz_q[1], 1'b1);
      wb_q <= finish(yaw4_q, q_q[0], rnz_q[0], 1'b1);
      wc_q <= finish(yaw4_q, q_q[1], rnz_q[1], 1'b0);
      wd_q <= finish(yaw4_q, q_q[0], rnz_q[0], 1'b0);
    end
  end

endmodule

// ===== src/omni_drive_mixer_heading_hold.sv =====
`timescale 1ns / 1ps

// Four-wheel omni drive mixer with proportional heading hold.
// Input channel (in_valid_i / in_ready_o): one beat carries speed, travel
// direction, yaw reference choice and the three bearing readings.
// Output channel (out_valid_o / out_ready_i): one beat of four signed wheel
// drives per input beat, in the order the inputs arrived.
// Config channel (cfg_valid_i / cfg_ready_o): index 0 compass gain, 1 target
// gain, 2 drive scale; other indexes are dropped. Write only while idle.
// Each accepted input beat passes a front register, a two-entry queue and a
// five-stage arithmetic back end.
// Throughput: one beat per cycle while outputs are taken; the back end issues
// one multiply per lane in stages 1-4 and the whole back end advances together.
// When the receiver stalls on a waiting output beat the back end holds; the
// queue then fills and in_ready_o drops once the queue is full and the front
// register holds a beat (at full rate, the cycle after the stall), nothing lost.
// Reset clears all valid state and loads gains 4 and 12 and scale 797.
module omni_drive_mixer_heading_hold (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [8:0]        speed_q8_i,
  input  logic [8:0]        travel_deg_i,
  input  logic [1:0]        heading_ref_i,
  input  logic signed [8:0] compass_error_i,
  input  logic [8:0]        goal_bearing_i,
  input  logic [8:0]        ball_bearing_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic signed [14:0] wheel_a_o,
  output logic signed [14:0] wheel_b_o,
  output logic signed [14:0] wheel_c_o,
  output logic signed [14:0] wheel_d_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [9:0]        cfg_data_i
);
  import odmix_pkg::*;

  logic [5:0]        gain_compass_q, gain_compass_d;
  logic [5:0]        gain_target_q, gain_target_d;
  logic [ScaleW-1:0] scale_mix_q, scale_mix_d;

  logic  fq_valid, fq_ready;
  item_t fq_item;
  logic  qb_valid, qb_ready;
  item_t qb_item;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    gain_compass_d = gain_compass_q;
    gain_target_d  = gain_target_q;
    scale_mix_d    = scale_mix_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgGainCompass: gain_compass_d = cfg_data_i[5:0];
        CfgGainTarget:  gain_target_d  = cfg_data_i[5:0];
        // the 0.707 ratio is folded into the stored scale
        CfgDriveScale:  scale_mix_d    = ScaleW'(cfg_data_i) * MixRatio;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_compass_q <= GainCompassReset;
      gain_target_q  <= GainTargetReset;
      scale_mix_q    <= ScaleW'(ScaleReset) * MixRatio;
    end else begin
      gain_compass_q <= gain_compass_d;
      gain_target_q  <= gain_target_d;
      scale_mix_q    <= scale_mix_d;
    end
  end

  odmix_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .speed_q8_i      (speed_q8_i),
    .travel_deg_i    (travel_deg_i),
    .heading_ref_i   (heading_ref_i),
    .compass_error_i (compass_error_i),
    .goal_bearing_i  (goal_bearing_i),
    .ball_bearing_i  (ball_bearing_i),
    .gain_compass_i  (gain_compass_q),
    .gain_target_i   (gain_target_q),
    .item_valid_o    (fq_valid),
    .item_o          (fq_item),
    .item_ready_i    (fq_ready)
  );

  odmix_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_item_i  (fq_item),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_item_o   (qb_item)
  );

  odmix_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (qb_valid),
    .item_ready_o (qb_ready),
    .item_i       (qb_item),
    .scale_mix_i  (scale_mix_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .wheel_a_o    (wheel_a_o),
    .wheel_b_o    (wheel_b_o),
    .wheel_c_o    (wheel_c_o),
    .wheel_d_o    (wheel_d_o)
  );

endmodule
